### rtl/deqr_pkg.sv
`timescale 1ns / 1ps

package deqr_pkg;

	// Default sizes handed to the top level
	localparam int DEPTH_DEF      = 256;
	localparam int DATA_WIDTH_DEF = 64;

	// Fixed field widths of the stream payload
	localparam int REQ_W   = 3;
	localparam int WORD_W  = 64;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 9;

	// Request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_ADD_FRONT = 3'd0,
		REQ_ADD_BACK  = 3'd1,
		REQ_RD_FRONT  = 3'd2,
		REQ_RD_BACK   = 3'd3,
		REQ_RM_FRONT  = 3'd4,
		REQ_RM_BACK   = 3'd5,
		REQ_REVERSE   = 3'd6
	} req_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Per-row shift and load controls, broadcast to every cell of a row
	typedef struct packed {
		logic push;  // shift toward the far end, cell 0 takes the new word
		logic pop;   // shift toward cell 0, dropping the head entry
		logic put;   // the cell whose index equals the count takes the new word
	} row_ctrl_t;

endpackage

### rtl/double_ended_queue_with_reverse.sv
`timescale 1ns / 1ps

// Channel  Dir  Signals                          Contents (lowest bit up)
// s        in   s_tvalid s_tready s_tdata s_tuser  tdata: data_word[63:0]
//                                                  tuser: req_type[2:0]
// m        out  m_tvalid m_tready m_tdata          tdata: read_word[63:0],
//                                                  status[65:64], is_empty[66],
//                                                  entry_count[75:67], zero[79:76]
//
// One request per clock while s_tready is high; its result shows in the output register on the next cycle.
// Two rows of DEPTH cells hold the entries, one in start-to-end order and one in
// end-to-start order, so both ends sit in cell 0 and a request does at most one shift or load per row.
// A held result stalls input only when m_tready is low and the output register is full.
// Reset clears the count, direction flag and output valid; the cells need no clearing.

module double_ended_queue_with_reverse #(
	parameter int DEPTH      = deqr_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deqr_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // data_word[63:0]
	input  logic [2:0]  s_tuser,   // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata    // read_word, status, is_empty, entry_count, zero pad
);
	import deqr_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [CNT_W-1:0]      cnt_q;
	logic                  rev_q;
	logic                  out_valid_q;
	logic [WORD_W-1:0]     read_word_q;
	status_t               status_q;
	logic                  empty_q;
	logic [COUNT_W-1:0]    count_out_q;

	logic                  accept;
	req_t                  req;
	logic [DATA_WIDTH-1:0] word;
	logic [DATA_WIDTH-1:0] start_head;
	logic [DATA_WIDTH-1:0] end_head;
	row_ctrl_t             start_ctrl;
	row_ctrl_t             end_ctrl;
	logic [CNT_W-1:0]      cnt_nxt;
	logic                  rev_nxt;
	status_t               status_nxt;
	logic [DATA_WIDTH-1:0] rd_nxt;
	logic                  is_full;
	logic                  is_empty;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign req      = req_t'(s_tuser);
	assign word     = s_tdata[DATA_WIDTH-1:0];
	assign is_full  = (cnt_q == FULL_CNT);
	assign is_empty = (cnt_q == '0);

	// Decode the request into row controls and next state
	always_comb begin
		start_ctrl = '0;
		end_ctrl   = '0;
		cnt_nxt    = cnt_q;
		rev_nxt    = rev_q;
		status_nxt = ST_OK;
		rd_nxt     = '0;
		if (accept) begin
			unique case (req)
				REQ_ADD_FRONT, REQ_ADD_BACK: begin
					if (is_full) begin
						status_nxt = ST_FULL;
					end else begin
						// logical front is the physical start unless reversed
						if ((req == REQ_ADD_FRONT) != rev_q) begin
							start_ctrl.push = 1'b1;
							end_ctrl.put    = 1'b1;
						end else begin
							end_ctrl.push  = 1'b1;
							start_ctrl.put = 1'b1;
						end
						cnt_nxt = cnt_q + 1'b1;
					end
				end
				REQ_RD_FRONT, REQ_RD_BACK: begin
					if (is_empty) begin
						status_nxt = ST_EMPTY;
					end else if ((req == REQ_RD_FRONT) != rev_q) begin
						rd_nxt = start_head;
					end else begin
						rd_nxt = end_head;
					end
				end
				REQ_RM_FRONT, REQ_RM_BACK: begin
					if (is_empty) begin
						status_nxt = ST_EMPTY;
					end else begin
						if ((req == REQ_RM_FRONT) != rev_q) begin
							start_ctrl.pop = 1'b1;
						end else begin
							end_ctrl.pop = 1'b1;
						end
						cnt_nxt = cnt_q - 1'b1;
					end
				end
				REQ_REVERSE: begin
					if (is_empty) begin
						status_nxt = ST_EMPTY;
					end else begin
						rev_nxt = !rev_q;
					end
				end
				default: begin
					status_nxt = ST_OK;
				end
			endcase
		end
	end

	// Row in start-to-end order
	deqr_row #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.CNT_W      (CNT_W)
	) u_start_row (
		.clk   (clk),
		.ctrl  (start_ctrl),
		.count (cnt_q),
		.word  (word),
		.head  (start_head)
	);

	// Row in end-to-start order
	deqr_row #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.CNT_W      (CNT_W)
	) u_end_row (
		.clk   (clk),
		.ctrl  (end_ctrl),
		.count (cnt_q),
		.word  (word),
		.head  (end_head)
	);

	// Hold count, direction and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rev_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_nxt;
			rev_q <= rev_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the result register on each accepted request
	always_ff @(posedge clk) begin
		if (accept) begin
			read_word_q <= WORD_W'(rd_nxt);
			status_q    <= status_nxt;
			empty_q     <= (cnt_nxt == '0);
			count_out_q <= COUNT_W'(cnt_nxt);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, count_out_q, empty_q, status_q, read_word_q};

	// Count never passes the row length
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("entry count beyond depth");

	// A dropped add leaves the count alone
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_full && (req == REQ_ADD_FRONT || req == REQ_ADD_BACK))
		|=> (cnt_q == $past(cnt_q)) && (status_q == ST_FULL))
		else $error("add while full changed the count");

	// A reverse on a non-empty queue flips the direction flag
	a_rev_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_empty && req == REQ_REVERSE) |=> (rev_q != $past(rev_q)))
		else $error("reverse did not flip direction");

	// Registered empty flag agrees with the live count
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (empty_q == (cnt_q == '0)))
		else $error("empty flag out of step with count");

endmodule

### rtl/deqr_cell.sv
`timescale 1ns / 1ps

module deqr_cell #(
	parameter int DATA_WIDTH = 64,
	parameter int CNT_W      = 9,
	parameter int INDEX      = 0
) (
	input  logic                   clk,
	input  deqr_pkg::row_ctrl_t    ctrl,
	input  logic [CNT_W-1:0]       count,
	input  logic [DATA_WIDTH-1:0]  word,
	input  logic [DATA_WIDTH-1:0]  prev_data,
	input  logic [DATA_WIDTH-1:0]  next_data,
	output logic [DATA_WIDTH-1:0]  data
);
	import deqr_pkg::*;

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;

	// Take the neighbor's word on a shift, or the new word at the fill edge
	always_ff @(posedge clk) begin
		priority if (ctrl.push) begin
			data_q <= prev_data;
		end else if (ctrl.pop) begin
			data_q <= next_data;
		end else if (ctrl.put && (count == IDX)) begin
			data_q <= word;
		end
	end

	assign data = data_q;

endmodule

### rtl/deqr_row.sv
`timescale 1ns / 1ps

module deqr_row #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 64,
	parameter int CNT_W      = 9
) (
	input  logic                   clk,
	input  deqr_pkg::row_ctrl_t    ctrl,
	input  logic [CNT_W-1:0]       count,
	input  logic [DATA_WIDTH-1:0]  word,
	output logic [DATA_WIDTH-1:0]  head
);
	import deqr_pkg::*;

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];

	// Chain the cells: each one sees its neighbors, with the new word before cell 0 and zero past the last
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_w;
		logic [DATA_WIDTH-1:0] next_w;

		if (i == 0) begin : g_first
			assign prev_w = word;
		end else begin : g_mid_prev
			assign prev_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_w = '0;
		end else begin : g_mid_next
			assign next_w = cell_data[i+1];
		end

		deqr_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CNT_W      (CNT_W),
			.INDEX      (i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.count     (count),
			.word      (word),
			.prev_data (prev_w),
			.next_data (next_w),
			.data      (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule
